@@ hw/rtl/rcs_pkg.sv @@
`default_nettype none
package rcs_pkg;

   localparam int PermDepth    = 256;
   localparam int MaxKeyBytes  = 256;
   localparam int KeyLenWidth  = 9;

   localparam logic [1:0] KIND_KEY  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   localparam logic [2:0] STAT_PENDING  = 3'd0;
   localparam logic [2:0] STAT_OK       = 3'd1;
   localparam logic [2:0] STAT_MISMATCH = 3'd2;
   localparam logic [2:0] STAT_SHORT    = 3'd3;
   localparam logic [2:0] STAT_NO_KEY   = 3'd4;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

   typedef struct packed {
      logic       clear;
      logic       feed;
      logic [7:0] data;
   } crc_ctl_type;

endpackage
`default_nettype wire

@@ hw/rtl/rcs_ram.sv @@
`default_nettype none
module rcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ hw/rtl/rcs_crc.sv @@
`default_nettype none
module rcs_crc (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rcs_pkg::crc_ctl_type ctl,
   output logic [31:0]               crc_value
);

   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic [31:0] step;

   always_comb begin
      step = crc_ff ^ {24'd0, ctl.data};
      for (int k = 0; k < 8; k++) begin
         step = step[0] ? (rcs_pkg::CRC_POLY ^ (step >> 1)) : (step >> 1);
      end
      crc_in = crc_ff;
      if (ctl.clear) begin
         crc_in = rcs_pkg::CRC_ONES;
      end else if (ctl.feed) begin
         crc_in = step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= rcs_pkg::CRC_ONES;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc_value = crc_ff ^ rcs_pkg::CRC_ONES;

endmodule
`default_nettype wire

@@ hw/rtl/rc4_crc32_sealed_frame.sv @@
`default_nettype none
// RC4 cipher with a CRC-32 seal, one byte item at a time. Key items are stored in a
// 256-byte key memory; the item with tlast set completes the key and starts the key
// schedule, which fills the permutation memory and then swaps through it, stepping
// through S_KS_RD, S_KS_J, S_KS_W1 and S_KS_W2 for each entry; no item is taken while
// it runs. The schedule runs again after a frame end or a mode write while a key is
// held. A data item passes through S_G_I, S_G_J, S_G_W1, S_G_W2, S_G_K, S_G_USE and
// S_EMIT: the keystream needs two dependent reads, two swap writes and one output read
// on the single port pair of the permutation memory, and S_EMIT loads the result once
// the output register is free. The block returns to S_IDLE before it takes the next
// item; a decrypting data item that only fills the hold gives no result.
// An encrypting frame end gives four CRC items. Only one item is in work at a time; a
// finished result sits in the output register while the next item is taken.
module rc4_crc32_sealed_frame (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // value[7:0]
   input  wire logic [1:0] req_tuser,   // kind[1:0]
   input  wire logic       req_tlast,   // key_last
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic      [7:0] rsp_tdata,   // out_byte[7:0]
   output logic      [3:0] rsp_tuser,   // has_byte[0], status[3:1]
   output logic            rsp_tlast,   // end_mark
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data  // mode
);

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_KS_RD, S_KS_J, S_KS_W1, S_KS_W2,
      S_G_I, S_G_J, S_G_W1, S_G_W2, S_G_K, S_G_USE, S_EMIT, S_RESTART
   } state_type;

   state_type state_ff, state_in, after_ff, after_in;
   logic       mode_ff, mode_in, keyed_ff, keyed_in, pend_ff, pend_in;
   logic [rcs_pkg::KeyLenWidth-1:0] len_ff, len_in;
   logic [7:0] n_ff, n_in, kidx_ff, kidx_in, i_ff, i_in, j_ff, j_in;
   logic [7:0] si_ff, si_in, sj_ff, sj_in, byte_ff, byte_in;
   logic       purp_ff, purp_in;
   logic [1:0] crck_ff, crck_in;
   logic [7:0] hold_ff [4];
   logic [7:0] hold_in [4];
   logic [2:0] hcnt_ff, hcnt_in;
   logic       rvalid_ff, rvalid_in, rhas_ff, rhas_in, rlast_ff, rlast_in;
   logic [7:0] rbyte_ff, rbyte_in;
   logic [2:0] rstat_ff, rstat_in;
   logic       qhas_ff, qhas_in, qlast_ff, qlast_in;
   logic [7:0] qbyte_ff, qbyte_in;
   logic [2:0] qstat_ff, qstat_in;

   logic       p_we, k_we;
   logic [7:0] p_waddr, p_wdata, p_raddr, p_rdata, k_waddr, k_wdata, k_raddr, k_rdata;
   rcs_pkg::crc_ctl_type crc_ctl;
   logic [31:0] crc_value;

   logic       out_free, req_acc;
   logic [rcs_pkg::KeyLenWidth-1:0] effl, lenc;
   logic [7:0] jn, x, crcb;
   logic [1:0] crck_next;

   rcs_ram #(.WIDTH(8), .DEPTH(rcs_pkg::PermDepth)) u_perm (
      .clock(clock), .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
      .rd_addr(p_raddr), .rd_data(p_rdata)
   );

   rcs_ram #(.WIDTH(8), .DEPTH(rcs_pkg::MaxKeyBytes)) u_key (
      .clock(clock), .wr_en(k_we), .wr_addr(k_waddr), .wr_data(k_wdata),
      .rd_addr(k_raddr), .rd_data(k_rdata)
   );

   rcs_crc u_crc (.clock(clock), .reset(reset), .ctl(crc_ctl), .crc_value(crc_value));

   assign req_tready = (state_ff == S_IDLE) && !pend_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rvalid_ff || rsp_tready;
   assign lenc       = (len_ff == 9'd0) ? 9'd1 : len_ff;
   assign crck_next  = crck_ff + 2'd1;

   always_comb begin
      case (crck_next)
         2'd0:    crcb = crc_value[31:24];
         2'd1:    crcb = crc_value[23:16];
         2'd2:    crcb = crc_value[15:8];
         default: crcb = crc_value[7:0];
      endcase
   end

   always_comb begin
      state_in = state_ff;  after_in = after_ff;
      mode_in  = mode_ff;   keyed_in = keyed_ff;  pend_in = pend_ff;
      len_in   = len_ff;    n_in     = n_ff;      kidx_in = kidx_ff;
      i_in     = i_ff;      j_in     = j_ff;      si_in   = si_ff;   sj_in = sj_ff;
      byte_in  = byte_ff;   purp_in  = purp_ff;   crck_in = crck_ff;
      hold_in  = hold_ff;   hcnt_in  = hcnt_ff;
      rvalid_in = rvalid_ff; rhas_in = rhas_ff; rlast_in = rlast_ff;
      rbyte_in  = rbyte_ff;  rstat_in = rstat_ff;
      qhas_in = qhas_ff; qlast_in = qlast_ff; qbyte_in = qbyte_ff; qstat_in = qstat_ff;
      p_we = 1'b0; p_waddr = n_ff; p_wdata = n_ff; p_raddr = n_ff;
      k_we = 1'b0; k_waddr = 8'd0; k_wdata = req_tdata; k_raddr = kidx_ff;
      crc_ctl = '{clear: 1'b0, feed: 1'b0, data: byte_ff};
      effl = keyed_ff ? 9'd0 : len_ff;
      jn   = j_ff + p_rdata;
      x    = byte_ff ^ p_rdata;

      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (pend_ff) begin
               pend_in = 1'b0;
               if (keyed_ff) begin
                  state_in = S_INIT;
                  n_in     = 8'd0;
               end
            end else if (req_acc) begin
               case (req_tuser)
                  rcs_pkg::KIND_KEY: begin
                     if (keyed_ff) begin
                        keyed_in = 1'b0;
                        crc_ctl.clear = 1'b1;
                        hcnt_in = 3'd0;
                     end
                     len_in = effl;
                     if (effl < 9'(rcs_pkg::MaxKeyBytes)) begin
                        k_we    = 1'b1;
                        k_waddr = effl[7:0];
                        len_in  = effl + 9'd1;
                     end
                     if (req_tlast) begin
                        keyed_in = 1'b1;
                        crc_ctl.clear = 1'b1;
                        hcnt_in  = 3'd0;
                        state_in = S_INIT;
                        n_in     = 8'd0;
                     end
                  end
                  rcs_pkg::KIND_DATA: begin
                     if (!keyed_ff) begin
                        qbyte_in = 8'd0; qhas_in = 1'b0; qlast_in = 1'b0;
                        qstat_in = rcs_pkg::STAT_NO_KEY;
                        state_in = S_EMIT; after_in = S_IDLE;
                     end else begin
                        byte_in  = req_tdata;
                        purp_in  = 1'b0;
                        state_in = S_G_I;
                     end
                  end
                  rcs_pkg::KIND_END: begin
                     if (!keyed_ff) begin
                        qbyte_in = 8'd0; qhas_in = 1'b0; qlast_in = 1'b1;
                        qstat_in = rcs_pkg::STAT_NO_KEY;
                        state_in = S_EMIT; after_in = S_IDLE;
                     end else if (!mode_ff) begin
                        crck_in  = 2'd0;
                        purp_in  = 1'b1;
                        byte_in  = crc_value[31:24];
                        state_in = S_G_I;
                     end else begin
                        qbyte_in = 8'd0; qhas_in = 1'b0; qlast_in = 1'b1;
                        if (hcnt_ff < 3'd4) begin
                           qstat_in = rcs_pkg::STAT_SHORT;
                        end else if ({hold_ff[0], hold_ff[1], hold_ff[2], hold_ff[3]}
                                     == crc_value) begin
                           qstat_in = rcs_pkg::STAT_OK;
                        end else begin
                           qstat_in = rcs_pkg::STAT_MISMATCH;
                        end
                        state_in = S_EMIT; after_in = S_RESTART;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INIT: begin
            p_we    = 1'b1;
            n_in    = n_ff + 8'd1;
            if (n_ff == 8'hFF) begin
               state_in = S_KS_RD;
               j_in     = 8'd0;
               kidx_in  = 8'd0;
            end
         end
         S_KS_RD: begin
            state_in = S_KS_J;
         end
         S_KS_J: begin
            si_in    = p_rdata;
            j_in     = jn + k_rdata;
            p_raddr  = jn + k_rdata;
            state_in = S_KS_W1;
         end
         S_KS_W1: begin
            p_we     = 1'b1;
            p_wdata  = p_rdata;
            state_in = S_KS_W2;
         end
         S_KS_W2: begin
            p_we    = 1'b1;
            p_waddr = j_ff;
            p_wdata = si_ff;
            n_in    = n_ff + 8'd1;
            kidx_in = (({1'b0, kidx_ff} + 9'd1) == lenc) ? 8'd0 : kidx_ff + 8'd1;
            if (n_ff == 8'hFF) begin
               i_in = 8'd0; j_in = 8'd0;
               state_in = S_IDLE;
            end else begin
               state_in = S_KS_RD;
            end
         end
         S_G_I: begin
            i_in     = i_ff + 8'd1;
            p_raddr  = i_ff + 8'd1;
            state_in = S_G_J;
         end
         S_G_J: begin
            si_in    = p_rdata;
            j_in     = jn;
            p_raddr  = jn;
            state_in = S_G_W1;
         end
         S_G_W1: begin
            sj_in    = p_rdata;
            p_we     = 1'b1;
            p_waddr  = i_ff;
            p_wdata  = p_rdata;
            state_in = S_G_W2;
         end
         S_G_W2: begin
            p_we     = 1'b1;
            p_waddr  = j_ff;
            p_wdata  = si_ff;
            state_in = S_G_K;
         end
         S_G_K: begin
            p_raddr  = si_ff + sj_ff;
            state_in = S_G_USE;
         end
         S_G_USE: begin
            if (purp_ff) begin
               qbyte_in = x; qhas_in = 1'b1;
               qlast_in = (crck_ff == 2'd3);
               qstat_in = (crck_ff == 2'd3) ? rcs_pkg::STAT_OK : rcs_pkg::STAT_PENDING;
               after_in = (crck_ff == 2'd3) ? S_RESTART : S_G_I;
               crck_in  = crck_next;
               byte_in  = crcb;
               state_in = S_EMIT;
            end else if (!mode_ff) begin
               crc_ctl.feed = 1'b1;
               qbyte_in = x; qhas_in = 1'b1; qlast_in = 1'b0;
               qstat_in = rcs_pkg::STAT_PENDING;
               state_in = S_EMIT; after_in = S_IDLE;
            end else if (hcnt_ff < 3'd4) begin
               hold_in[hcnt_ff[1:0]] = x;
               hcnt_in  = hcnt_ff + 3'd1;
               state_in = S_IDLE;
            end else begin
               // release the oldest held byte, shift the rest down
               crc_ctl.feed = 1'b1;
               crc_ctl.data = hold_ff[0];
               qbyte_in = hold_ff[0]; qhas_in = 1'b1; qlast_in = 1'b0;
               qstat_in = rcs_pkg::STAT_PENDING;
               hold_in[0] = hold_ff[1];
               hold_in[1] = hold_ff[2];
               hold_in[2] = hold_ff[3];
               hold_in[3] = x;
               state_in = S_EMIT; after_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rvalid_in = 1'b1;
               rbyte_in  = qbyte_ff; rhas_in = qhas_ff;
               rlast_in  = qlast_ff; rstat_in = qstat_ff;
               state_in  = after_ff;
            end
         end
         S_RESTART: begin
            crc_ctl.clear = 1'b1;
            hcnt_in = 3'd0;
            if (keyed_ff) begin
               state_in = S_INIT;
               n_in     = 8'd0;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         mode_in = csr_wr_data;
         crc_ctl.clear = 1'b1;
         hcnt_in = 3'd0;
         pend_in = keyed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         after_ff  <= S_IDLE;
         mode_ff   <= 1'b0;
         keyed_ff  <= 1'b0;
         pend_ff   <= 1'b0;
         len_ff    <= 9'd0;
         hcnt_ff   <= 3'd0;
         i_ff      <= 8'd0;
         j_ff      <= 8'd0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         after_ff  <= after_in;
         mode_ff   <= mode_in;
         keyed_ff  <= keyed_in;
         pend_ff   <= pend_in;
         len_ff    <= len_in;
         hcnt_ff   <= hcnt_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         rvalid_ff <= rvalid_in;
      end
      n_ff     <= n_in;
      kidx_ff  <= kidx_in;
      si_ff    <= si_in;
      sj_ff    <= sj_in;
      byte_ff  <= byte_in;
      purp_ff  <= purp_in;
      crck_ff  <= crck_in;
      hold_ff  <= hold_in;
      rbyte_ff <= rbyte_in;
      rhas_ff  <= rhas_in;
      rlast_ff <= rlast_in;
      rstat_ff <= rstat_in;
      qbyte_ff <= qbyte_in;
      qhas_ff  <= qhas_in;
      qlast_ff <= qlast_in;
      qstat_ff <= qstat_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rbyte_ff;
   assign rsp_tuser  = {rstat_ff, rhas_ff};
   assign rsp_tlast  = rlast_ff;

`ifndef ASSERT_OFF
   a_hold_range: assert property (@(posedge clock) disable iff (reset)
      hcnt_ff <= 3'd4) else $error("hold count out of range");

   a_no_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && !rhas_ff |-> rbyte_ff == 8'd0) else $error("stray byte on empty result");

   a_end_status: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && rlast_ff |-> rstat_ff != rcs_pkg::STAT_PENDING)
      else $error("frame end without status");

   a_key_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(keyed_ff) |-> $past(req_acc && req_tuser == rcs_pkg::KIND_KEY))
      else $error("key lost without key item");
`endif

endmodule
`default_nettype wire
